// ----- design/bcgd_pkg.sv -----
package bcgd_pkg;

  // Phases of the gesture state machine.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DOWN1 = 3'd1,
    PH_UP1   = 3'd2,
    PH_DOWN2 = 3'd3,
    PH_HOLD  = 3'd4
  } phase_t;

  // Gesture codes as presented on the result channel.
  typedef enum logic [1:0] {
    G_NONE   = 2'd0,
    G_CLICK  = 2'd1,
    G_DOUBLE = 2'd2,
    G_HOLD   = 2'd3
  } gesture_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOUBLE_INTERVAL = 2'd0,
    CFG_HOLD_TIME       = 2'd1,
    CFG_PRESSED_LEVEL   = 2'd2,
    CFG_SETTLE          = 2'd3
  } cfg_index_t;

  // Register reset values.
  localparam logic [15:0] DOUBLE_INTERVAL_RST = 16'd300;
  localparam logic [15:0] HOLD_TIME_RST       = 16'd1000;
  localparam logic        PRESSED_LEVEL_RST   = 1'b0;
  localparam logic [7:0]  SETTLE_RST          = 8'd20;

  localparam int TIME_W = 32;

endpackage

// ----- design/button_click_gesture_detector_core.sv -----
// Button gesture detector. Each input transaction carries one sample of the raw
// button level with the current millisecond time; each produces exactly one
// result transaction whose gesture field reads none, single click, double
// click or hold. Click and double click appear for one result only, while hold
// persists until the button is released. Changes are ignored for settle_ms after
// each accepted edge, except a release from hold, and all time differences wrap
// modulo 2^32. The block takes one sample per clock while the result is not
// stalled: a sample is held in the input register, and the state machine and
// the result register are then updated together once the result register is
// free. A stalled result holds the input register and then the input channel.
// Configuration writes are always ready and must only be issued while the block
// holds no sample in flight.
module button_click_gesture_detector_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // Sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 button_level,
  input  logic [bcgd_pkg::TIME_W-1:0]          now_ms,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           gesture,
  // Configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bcgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcgd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bcgd_pkg::*;

  // Configuration registers
  logic [15:0] double_interval_ms;
  logic [15:0] hold_time_ms;
  logic        pressed_level;
  logic [7:0]  settle_ms;

  // Input register
  logic              s1_valid;
  logic              level_q;
  logic [TIME_W-1:0] now_q;

  // Machine state
  phase_t            phase, phase_next;
  gesture_t          reported_gesture, reported_gesture_next;
  logic [TIME_W-1:0] last_edge_time, last_edge_time_next;
  logic [TIME_W-1:0] press_start_time, press_start_time_next;
  logic [TIME_W-1:0] release_time, release_time_next;

  logic out_free;
  logic advance;
  logic pressed;
  logic settled;
  logic hold_due;
  logic interval_over;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_interval_ms <= DOUBLE_INTERVAL_RST;
      hold_time_ms       <= HOLD_TIME_RST;
      pressed_level      <= PRESSED_LEVEL_RST;
      settle_ms          <= SETTLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DOUBLE_INTERVAL: double_interval_ms <= cfg_data;
        CFG_HOLD_TIME:       hold_time_ms       <= cfg_data;
        CFG_PRESSED_LEVEL:   pressed_level      <= cfg_data[0];
        CFG_SETTLE:          settle_ms          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: the sample advances when the result register is free or
  // its current result is being taken in this cycle.
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      level_q <= button_level;
      now_q   <= now_ms;
    end
  end

  // Time comparisons on wrapped differences.
  assign pressed       = (level_q == pressed_level);
  assign settled       = (now_q - last_edge_time) > {24'd0, settle_ms};
  assign hold_due      = (now_q - press_start_time) > {16'd0, hold_time_ms};
  assign interval_over = (now_q - release_time) > {16'd0, double_interval_ms};

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HOLD: begin
        if (!pressed) phase_next = PH_IDLE;
      end
      PH_DOWN1: begin
        if (settled) begin
          priority if (!pressed) phase_next = PH_UP1;
          else if (hold_due)     phase_next = PH_HOLD;
          else                   phase_next = phase;
        end
      end
      PH_UP1: begin
        if (settled) begin
          priority if (interval_over) phase_next = PH_IDLE;
          else if (pressed)           phase_next = PH_DOWN2;
          else                        phase_next = phase;
        end
      end
      PH_DOWN2: begin
        if (settled) begin
          priority if (!pressed) phase_next = PH_IDLE;
          else if (hold_due)     phase_next = PH_HOLD;
          else                   phase_next = phase;
        end
      end
      PH_IDLE: begin
        if (settled && pressed) phase_next = PH_DOWN1;
      end
      default: begin
        phase_next = PH_IDLE;
        if (settled && pressed) phase_next = PH_DOWN1;
      end
    endcase
  end

  // Gesture and time stamps.
  always_comb begin
    reported_gesture_next = reported_gesture;
    last_edge_time_next   = last_edge_time;
    press_start_time_next = press_start_time;
    release_time_next     = release_time;
    // One-shot gestures last a single result.
    if (reported_gesture == G_CLICK || reported_gesture == G_DOUBLE) begin
      reported_gesture_next = G_NONE;
    end
    unique case (phase)
      PH_HOLD: begin
        if (!pressed) begin
          reported_gesture_next = G_NONE;
          last_edge_time_next   = now_q;
        end
      end
      PH_DOWN1: begin
        if (settled) begin
          priority if (!pressed) begin
            release_time_next   = now_q;
            last_edge_time_next = now_q;
          end else if (hold_due) begin
            reported_gesture_next = G_HOLD;
          end else begin
            // Still pressed and not yet long enough for a hold.
          end
        end
      end
      PH_UP1: begin
        if (settled) begin
          priority if (interval_over) begin
            reported_gesture_next = G_CLICK;
          end else if (pressed) begin
            press_start_time_next = now_q;
            last_edge_time_next   = now_q;
          end else begin
            // Still released and within the double-click interval.
          end
        end
      end
      PH_DOWN2: begin
        if (settled) begin
          priority if (!pressed) begin
            last_edge_time_next   = now_q;
            reported_gesture_next = G_DOUBLE;
          end else if (hold_due) begin
            reported_gesture_next = G_HOLD;
          end else begin
            // Still pressed and not yet long enough for a hold.
          end
        end
      end
      default: begin
        if (settled && pressed) begin
          press_start_time_next = now_q;
          last_edge_time_next   = now_q;
        end
      end
    endcase
  end

  // State update; the reported gesture doubles as the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      reported_gesture <= G_NONE;
      last_edge_time   <= '0;
      press_start_time <= '0;
      release_time     <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      reported_gesture <= reported_gesture_next;
      last_edge_time   <= last_edge_time_next;
      press_start_time <= press_start_time_next;
      release_time     <= release_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign gesture = reported_gesture;

  // Checks on the state machine and the pipeline.
  a_hold_reported: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HOLD) |-> (reported_gesture == G_HOLD))
    else $error("hold phase without hold gesture");

  a_click_from_idle: assert property (@(posedge clk) disable iff (rst)
    (reported_gesture == G_CLICK || reported_gesture == G_DOUBLE) |-> (phase == PH_IDLE))
    else $error("click reported outside idle phase");

  a_click_one_shot: assert property (@(posedge clk) disable iff (rst)
    (advance && (reported_gesture == G_CLICK || reported_gesture == G_DOUBLE))
      |=> (reported_gesture != G_CLICK && reported_gesture != G_DOUBLE))
    else $error("one-shot gesture repeated");

  a_hold_release: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == PH_HOLD && !pressed) |=>
      (phase == PH_IDLE && reported_gesture == G_NONE))
    else $error("release from hold not handled");

  a_no_advance_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(phase) && $stable(last_edge_time))
    else $error("state moved while result stalled");

endmodule

// ----- test/tb_button_click_gesture_detector_core.sv -----
`timescale 1ns / 1ps

module tb_button_click_gesture_detector_core;
  import bcgd_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_OFF_LEN  = 200;
  localparam int RANDOM_CHUNK  = 350;

  // Clock, reset and block ports, with all block inputs at known values from the start.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  button_level = 1'b0;
  logic [TIME_W-1:0]     now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            gesture;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the configuration and of the gesture machine.
  logic [15:0]       m_double_interval = DOUBLE_INTERVAL_RST;
  logic [15:0]       m_hold_time       = HOLD_TIME_RST;
  logic              m_pressed_level   = PRESSED_LEVEL_RST;
  logic [7:0]        m_settle          = SETTLE_RST;
  phase_t            m_phase           = PH_IDLE;
  gesture_t          m_gesture         = G_NONE;
  logic [TIME_W-1:0] m_last_edge       = '0;
  logic [TIME_W-1:0] m_press_start     = '0;
  logic [TIME_W-1:0] m_release_at      = '0;

  gesture_t          expected_gestures[$];
  int                fail_count   = 0;
  int                result_count = 0;
  int                items_sent   = 0;
  int                idle_cycles  = 0;
  int                tx_idle_pct  = 0;
  int                rx_idle_pct  = 0;
  int                hold_off_req = 0;
  int                hold_off_seen = 0;
  int                hold_left    = 0;
  logic [TIME_W-1:0] cur_ms       = '0;

  button_click_gesture_detector_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .button_level (button_level),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gesture      (gesture),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one sample to the shadow machine and returns the gesture it reports.
  function automatic gesture_t predict_gesture(input logic lvl, input logic [TIME_W-1:0] now);
    logic              pressed;
    logic              settled;
    logic [TIME_W-1:0] since_edge;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_release;
    pressed       = (lvl == m_pressed_level);
    since_edge    = now - m_last_edge;
    since_press   = now - m_press_start;
    since_release = now - m_release_at;
    settled       = (since_edge > {24'd0, m_settle});
    // One-sample gestures are withdrawn on the next sample.
    if (m_gesture == G_CLICK || m_gesture == G_DOUBLE) m_gesture = G_NONE;
    case (m_phase)
      PH_HOLD: begin
        // Releasing from hold does not wait for the settle time.
        if (!pressed) begin
          m_phase     = PH_IDLE;
          m_gesture   = G_NONE;
          m_last_edge = now;
        end
      end
      PH_DOWN1: begin
        if (settled) begin
          if (!pressed) begin
            m_phase      = PH_UP1;
            m_release_at = now;
            m_last_edge  = now;
          end else if (since_press > {16'd0, m_hold_time}) begin
            m_phase   = PH_HOLD;
            m_gesture = G_HOLD;
          end
        end
      end
      PH_UP1: begin
        // The click timeout takes precedence over a second press.
        if (settled) begin
          if (since_release > {16'd0, m_double_interval}) begin
            m_phase   = PH_IDLE;
            m_gesture = G_CLICK;
          end else if (pressed) begin
            m_phase       = PH_DOWN2;
            m_press_start = now;
            m_last_edge   = now;
          end
        end
      end
      PH_DOWN2: begin
        if (settled) begin
          if (!pressed) begin
            m_phase     = PH_IDLE;
            m_last_edge = now;
            m_gesture   = G_DOUBLE;
          end else if (since_press > {16'd0, m_hold_time}) begin
            m_phase   = PH_HOLD;
            m_gesture = G_HOLD;
          end
        end
      end
      default: begin
        m_phase = PH_IDLE;
        if (settled && pressed) begin
          m_phase       = PH_DOWN1;
          m_press_start = now;
          m_last_edge   = now;
        end
      end
    endcase
    return m_gesture;
  endfunction

  // Counts a failure and reports only the first few.
  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Offers one sample transaction, after idle cycles drawn at the sender's idle
  // rate, and records the expectation.
  task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] now);
    if ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    button_level <= lvl;
    now_ms       <= now;
    do @(posedge clk); while (in_stall);
    expected_gestures.push_back(predict_gesture(lvl, now));
    items_sent++;
  endtask

  // Writes one register and mirrors it in the shadow configuration.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DOUBLE_INTERVAL: m_double_interval = data;
      CFG_HOLD_TIME:       m_hold_time       = data;
      CFG_PRESSED_LEVEL:   m_pressed_level   = data[0];
      CFG_SETTLE:          m_settle          = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] interval, input logic [15:0] hold_ms,
                            input logic [15:0] level_word, input logic [15:0] settle_word);
    write_reg(CFG_DOUBLE_INTERVAL, interval);
    write_reg(CFG_HOLD_TIME, hold_ms);
    write_reg(CFG_PRESSED_LEVEL, level_word);
    write_reg(CFG_SETTLE, settle_word);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering samples and waits until every expected result has arrived.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_gestures.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Holds the button at one level for a span, with occasional bounces.
  task automatic drive_segment(input bit press, input int unsigned span_ms,
                               input int unsigned step_max);
    int unsigned covered;
    int unsigned step;
    logic        lvl;
    covered = 0;
    do begin
      step = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, step_max);
      covered += step;
      cur_ms = cur_ms + step;
      lvl = press ? m_pressed_level : ~m_pressed_level;
      if ($urandom_range(99) < 10) lvl = ~lvl;
      send_sample(lvl, cur_ms);
    end while (covered <= span_ms);
  endtask

  // Plays one gesture shaped around the current thresholds, or a burst of noise.
  task automatic play_gesture();
    int unsigned st;
    int unsigned di;
    int unsigned ht;
    int unsigned sm;
    int unsigned kind;
    int unsigned n;
    st   = m_settle;
    di   = m_double_interval;
    ht   = m_hold_time;
    sm   = (st + di + ht) / 48 + 1;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        drive_segment(1'b1, $urandom_range(0, 2 * st + ht / 2 + 4), sm);
        drive_segment(1'b0, di + st + $urandom_range(0, 2 * sm + 4), sm);
      end
      2, 3: begin
        drive_segment(1'b1, $urandom_range(0, 2 * st + ht / 2 + 4), sm);
        drive_segment(1'b0, $urandom_range(0, di + st), sm);
        drive_segment(1'b1, $urandom_range(0, 2 * st + ht / 2 + 4), sm);
        drive_segment(1'b0, st + $urandom_range(0, 2 * sm + 4), sm);
      end
      4: begin
        drive_segment(1'b1, ht + st + $urandom_range(0, 3 * sm + 10), sm);
        drive_segment(1'b0, st + $urandom_range(0, 2 * sm + 4), sm);
      end
      5: begin
        drive_segment(1'b1, $urandom_range(0, 2 * st + 4), sm);
        drive_segment(1'b0, $urandom_range(0, di), sm);
        drive_segment(1'b1, ht + st + $urandom_range(0, 3 * sm + 10), sm);
        drive_segment(1'b0, st + $urandom_range(0, 2 * sm + 4), sm);
      end
      6, 7: begin
        n = $urandom_range(2, 8);
        repeat (n) begin
          if ($urandom_range(1)) cur_ms = $urandom();
          else cur_ms = cur_ms + $urandom_range(0, 3 * sm);
          send_sample(1'($urandom_range(1)), cur_ms);
        end
      end
      8: begin
        cur_ms = cur_ms + $urandom();
        drive_segment(1'($urandom_range(1)), $urandom_range(0, di + ht), sm);
      end
      default: begin
        drive_segment(1'($urandom_range(1)), $urandom_range(0, di + ht + st), sm);
      end
    endcase
  endtask

  // Picks a configuration, mostly with small thresholds and now and then an extreme.
  task automatic randomise_config();
    logic [15:0] interval;
    logic [15:0] hold_ms;
    logic [15:0] settle_word;
    interval = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                        : 16'($urandom_range(0, 80));
    hold_ms  = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                        : 16'($urandom_range(0, 150));
    settle_word = {8'($urandom()), ($urandom_range(7) == 0) ?
                   ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 20))};
    set_config(interval, hold_ms, 16'($urandom()), settle_word);
  endtask

  // Exact threshold crossings under the reset configuration, including time wrap.
  task automatic test_directed_edges();
    send_sample(1'b1, 32'd5);
    send_sample(1'b0, 32'd20);
    send_sample(1'b0, 32'd21);
    send_sample(1'b1, 32'd41);
    send_sample(1'b1, 32'd42);
    send_sample(1'b0, 32'd342);
    send_sample(1'b1, 32'd363);
    send_sample(1'b1, 32'd364);
    send_sample(1'b0, 32'd400);
    send_sample(1'b0, 32'd1400);
    send_sample(1'b0, 32'd1401);
    send_sample(1'b0, 32'd1402);
    send_sample(1'b1, 32'd1403);
    send_sample(1'b0, 32'd1424);
    send_sample(1'b1, 32'd1445);
    send_sample(1'b1, 32'd1746);
    send_sample(1'b1, 32'd1747);
    send_sample(1'b0, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'h0000_0010);
    send_sample(1'b0, 32'h0000_0030);
    send_sample(1'b0, 32'd1049);
    send_sample(1'b1, 32'd1050);
    send_sample(1'b0, 32'd1100);
    send_sample(1'b1, 32'd1130);
    send_sample(1'b0, 32'd1431);
    send_sample(1'b0, 32'hFFFF_FFFF);
    wait_drain();
  endtask

  // All thresholds at zero, then all at their largest values.
  task automatic test_config_extremes();
    set_config(16'h0000, 16'h0000, 16'h0001, 16'h0000);
    cur_ms = $urandom();
    repeat (10) play_gesture();
    wait_drain();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
    repeat (3) play_gesture();
    wait_drain();
  endtask

  // Random gestures, with a fresh configuration roughly every hundred samples.
  task automatic test_random_gestures(input int count);
    int target;
    int next_cfg;
    target   = items_sent + count;
    next_cfg = items_sent;
    cur_ms   = $urandom();
    while (items_sent < target) begin
      if (items_sent >= next_cfg) begin
        wait_drain();
        randomise_config();
        next_cfg = items_sent + 100;
      end
      play_gesture();
    end
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    int saved_tx;
    saved_tx = tx_idle_pct;
    tx_idle_pct = 0;
    set_config(16'd40, 16'd90, 16'($urandom()), 16'd6);
    hold_off_req++;
    repeat (60) begin
      cur_ms = cur_ms + $urandom_range(0, 12);
      send_sample(1'($urandom_range(1)), cur_ms);
    end
    tx_idle_pct = saved_tx;
    wait_drain();
  endtask

  // The sender pauses until every result is back, then carries on mid-gesture.
  task automatic test_drain_pause();
    set_config(16'd50, 16'd80, 16'($urandom()), 16'd4);
    repeat (4) begin
      drive_segment(1'b1, $urandom_range(0, 30), 6);
      wait_drain();
      drive_segment(1'b0, $urandom_range(0, 70), 6);
      wait_drain();
    end
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen = hold_off_req;
      hold_left     = HOLD_OFF_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Each accepted result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    gesture_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_gestures.size() == 0) begin
        note_failure($sformatf("result %0d arrived with nothing expected, gesture %0d",
                               result_count, gesture));
      end else begin
        want = expected_gestures.pop_front();
        if (gesture !== want)
          note_failure($sformatf("result %0d: expected gesture %0d, got %0d",
                                 result_count, want, gesture));
      end
      result_count++;
    end
  end

  // Watchdog on cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 21;
    rx_idle_pct = 65;
    test_directed_edges();
    test_config_extremes();
    test_random_gestures(RANDOM_CHUNK);

    tx_idle_pct = 65;
    rx_idle_pct = 21;
    test_random_gestures(RANDOM_CHUNK);
    test_drain_pause();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_gestures(RANDOM_CHUNK);
    test_backpressure();

    wait_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/bcgd_pkg.sv
design/button_click_gesture_detector_core.sv
test/tb_button_click_gesture_detector_core.sv
